/* src/assert_macros.svh */
// assertion helpers; the including module supplies i_clk and i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/deq_pkg.sv */
`timescale 1ns / 1ps
package deq_pkg;

    localparam int ITEM_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ_FWD   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_REV   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     valid;
        logic signed [ITEM_W-1:0] item;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } t_res;

endpackage

/* src/deq_if.sv */
`timescale 1ns / 1ps
interface deq_cmd_if import deq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [ITEM_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

interface deq_res_if import deq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ITEM_W-1:0] item;
    logic [STATUS_W-1:0]      status;
    logic                     last;

    modport source (output valid, output item, output status, output last, input ready);
    modport sink (input valid, input item, input status, input last, output ready);
endinterface

/* src/deq_ram.sv */
`timescale 1ns / 1ps
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/deq_out.sv */
`timescale 1ns / 1ps
module deq_out import deq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_res            i_res,
    output logic            o_free,
    deq_res_if.source       o_res
);

    logic                     r_valid;
    logic signed [ITEM_W-1:0] r_item;
    logic [STATUS_W-1:0]      r_status;
    logic                     r_last;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.valid) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_item   <= i_res.item;
            r_status <= i_res.status;
            r_last   <= i_res.last;
        end
    end

    assign o_res.valid  = r_valid;
    assign o_res.item   = r_item;
    assign o_res.status = r_status;
    assign o_res.last   = r_last;

endmodule

/* src/deq_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module deq_ctrl import deq_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    deq_cmd_if.sink                  i_cmd,
    input  logic                     i_out_free,
    output t_res                     o_res,
    output logic                     o_wr_en,
    output logic [$clog2(DEPTH)-1:0] o_wr_addr,
    output logic [ITEM_W-1:0]        o_wr_data,
    output logic                     o_rd_en,
    output logic [$clog2(DEPTH)-1:0] o_rd_addr,
    input  logic [ITEM_W-1:0]        i_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_STREAM = 1'b1;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        ring_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
        ring_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    logic          r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_left, n_left;
    logic          r_rev, n_rev;
    logic          r_pend, n_pend;
    logic          r_pend_last, n_pend_last;

    logic          cmd_acc;
    logic          full;
    logic          empty;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail_pos;
    logic [AW-1:0] back_pos;
    logic          load;
    logic          issue;

    assign i_cmd.ready = (r_state == S_IDLE) && i_out_free;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    // ring position one past the back entry, and of the back entry itself
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign back_pos = ring_dec(tail_pos);

    // stream: read data waits in the ram output until the output slot frees
    assign load  = r_pend && i_out_free;
    assign issue = (r_state == S_STREAM) && (r_left != '0) && (!r_pend || load);

    assign o_wr_data = i_cmd.value;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_pos       = r_pos;
        n_left      = r_left;
        n_rev       = r_rev;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        o_wr_en     = 1'b0;
        o_wr_addr   = tail_pos;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_pos;
        o_res       = '0;
        o_res.last  = 1'b1;

        if (r_state == S_IDLE) begin
            if (cmd_acc) begin
                unique case (i_cmd.mode)
                    MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                        o_res.valid = 1'b1;
                        if (full) begin
                            o_res.status = ST_FULL;
                        end else begin
                            o_wr_en = 1'b1;
                            n_count = r_count + CW'(1);
                            if (i_cmd.mode == MODE_PUSH_FRONT) begin
                                o_wr_addr = ring_dec(r_head);
                                n_head    = ring_dec(r_head);
                            end
                        end
                    end
                    MODE_POP_FRONT, MODE_POP_BACK: begin
                        if (empty) begin
                            o_res.valid  = 1'b1;
                            o_res.status = ST_EMPTY;
                        end else begin
                            n_state = S_STREAM;
                            n_left  = CW'(1);
                            n_count = r_count - CW'(1);
                            if (i_cmd.mode == MODE_POP_FRONT) begin
                                n_pos  = r_head;
                                n_head = ring_inc(r_head);
                            end else begin
                                n_pos = back_pos;
                            end
                        end
                    end
                    MODE_READ_FWD, MODE_READ_REV: begin
                        if (empty) begin
                            o_res.valid  = 1'b1;
                            o_res.status = ST_EMPTY;
                        end else begin
                            n_state = S_STREAM;
                            n_left  = r_count;
                            n_rev   = (i_cmd.mode == MODE_READ_REV);
                            n_pos   = (i_cmd.mode == MODE_READ_REV) ? back_pos : r_head;
                        end
                    end
                    default: begin
                        // unused modes: taken and dropped
                    end
                endcase
            end
        end else begin
            if (load) begin
                o_res.valid  = 1'b1;
                o_res.item   = i_rd_data;
                o_res.status = ST_OK;
                o_res.last   = r_pend_last;
            end
            if (issue) begin
                o_rd_en     = 1'b1;
                n_pos       = r_rev ? ring_dec(r_pos) : ring_inc(r_pos);
                n_left      = r_left - CW'(1);
                n_pend_last = (r_left == CW'(1));
                n_pend      = 1'b1;
            end else if (load) begin
                n_pend = 1'b0;
            end
            if ((r_left == '0) && (!r_pend || load)) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_left  <= n_left;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_rev       <= n_rev;
        r_pend_last <= n_pend_last;
    end

    `ASSERT_CLK(a_count_range, r_count <= CW'(DEPTH), "entry count above depth")
    `ASSERT_CLK(a_no_rw_overlap, !(o_wr_en && o_rd_en), "ram write and read in one cycle")
    `ASSERT_CLK(a_load_slot_free, o_res.valid |-> i_out_free, "item loaded into busy output")
    `ASSERT_NEXT(a_pend_held, r_pend && !i_out_free, r_pend && $stable(i_rd_data), "pending item lost")

endmodule

/* src/double_ended_queue.sv */
`timescale 1ns / 1ps
// bounded double-ended queue of signed 32-bit values in a ring of DEPTH ram entries
// i_cmd: valid/ready command channel carrying mode and value
//   push front/back, pop front/back, read all forward/reverse; modes 6 and 7 are dropped
// o_res: valid/ready result channel carrying item, status (ok, empty, full) and last
//   a pop or push gives one item; a read-out gives one item per entry, last on the final
//   one; empty or full gives one error item with item 0 and last set
// a push result shows on o_res the cycle after the command is taken; pop and read-out
//   items pass the ram output and o_res registers, one per cycle while o_res is ready
// pushes one per cycle while o_res is ready; a pop or a read-out holds i_cmd until its
//   last item is loaded, set by the single ram read port and its read latency
// a stalled o_res holds its item; any new command is then refused until the slot frees,
//   and a read-out pauses with its next entry parked in the ram output register
// reset (i_rst_n low, synchronous) empties the queue; ram contents are not cleared
module double_ended_queue import deq_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_cmd_if.sink    i_cmd,
    deq_res_if.source  o_res
);

    localparam int AW = $clog2(DEPTH);

    t_res              res_c;
    logic              out_free;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ITEM_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [ITEM_W-1:0] rd_data;

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_out_free (out_free),
        .o_res      (res_c),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    deq_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    deq_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res_c),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule

/* tb/double_ended_queue_test.sv */
`timescale 1ns / 1ps
module double_ended_queue_test;
    import deq_pkg::*;

    localparam int DEPTH = 64;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    // modes the block drops without a result
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [ITEM_W-1:0] item;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } deq_result_t;

    logic i_clk;
    logic i_rst_n;

    deq_cmd_if cmd_ch ();
    deq_res_if res_ch ();

    double_ended_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // shadow of the queue contents
    logic signed [ITEM_W-1:0] ring_mem [DEPTH];
    int unsigned              front_pos;
    int unsigned              fill_count;

    deq_result_t pending_results[$];
    int unsigned error_count;
    int unsigned idle_cycles;
    int unsigned rcv_wait;
    bit          no_idle;
    bit          hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void expect_result(logic signed [ITEM_W-1:0] item,
                                          logic [STATUS_W-1:0] status, logic last);
        deq_result_t r;
        r.item = item;
        r.status = status;
        r.last = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_command(logic [MODE_W-1:0] mode,
                                            logic signed [ITEM_W-1:0] value);
        int unsigned off;
        case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (fill_count >= DEPTH) begin
                    expect_result('0, ST_FULL, 1'b1);
                end else begin
                    if (mode == MODE_PUSH_FRONT) begin
                        front_pos = (front_pos + DEPTH - 1) % DEPTH;
                        ring_mem[front_pos] = value;
                    end else begin
                        ring_mem[(front_pos + fill_count) % DEPTH] = value;
                    end
                    fill_count++;
                    expect_result('0, ST_OK, 1'b1);
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                if (fill_count == 0) begin
                    expect_result('0, ST_EMPTY, 1'b1);
                end else if (mode == MODE_POP_FRONT) begin
                    expect_result(ring_mem[front_pos], ST_OK, 1'b1);
                    front_pos = (front_pos + 1) % DEPTH;
                    fill_count--;
                end else begin
                    expect_result(ring_mem[(front_pos + fill_count - 1) % DEPTH], ST_OK, 1'b1);
                    fill_count--;
                end
            end
            MODE_READ_FWD, MODE_READ_REV: begin
                if (fill_count == 0) begin
                    expect_result('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < fill_count; i++) begin
                        off = (mode == MODE_READ_FWD) ? i : fill_count - 1 - i;
                        expect_result(ring_mem[(front_pos + off) % DEPTH], ST_OK,
                                      i + 1 == fill_count);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [ITEM_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // offer one item and return at the edge where it is taken; valid stays high
    task automatic send_cmd(logic [MODE_W-1:0] mode, logic signed [ITEM_W-1:0] value);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.mode  <= mode;
        cmd_ch.value <= value;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        predict_command(mode, value);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // receiver: draws a stall after each item, or holds off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            rcv_wait = 0;
        end else if (hold_req) begin
            res_ch.ready <= 1'b0;
            rcv_wait = HOLD_CYCLES;
            hold_req = 1'b0;
        end else if (rcv_wait > 0) begin
            rcv_wait--;
            if (rcv_wait == 0)
                res_ch.ready <= 1'b1;
        end else if (!res_ch.ready) begin
            res_ch.ready <= 1'b1;
        end else if (res_ch.valid) begin
            rcv_wait = no_idle ? 0 : $urandom_range(0, 8);
            if (rcv_wait > 0)
                res_ch.ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        deq_result_t want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item: expected none, got item %0d status %0d last %0d",
                         $time, res_ch.item, res_ch.status, res_ch.last);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_ch.item !== want.item) begin
                    $display("%0t: item mismatch: expected %0d, got %0d",
                             $time, want.item, res_ch.item);
                    error_count++;
                end
                if (res_ch.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, res_ch.status);
                    error_count++;
                end
                if (res_ch.last !== want.last) begin
                    $display("%0t: last mismatch: expected %0d, got %0d",
                             $time, want.last, res_ch.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_cmd(MODE_READ_FWD, 32'sd5);
        send_cmd(MODE_READ_REV, -32'sd5);
        send_cmd(MODE_POP_FRONT, 32'sd0);
        send_cmd(MODE_POP_BACK, 32'sd0);
        send_cmd(MODE_PUSH_BACK, 32'sh7fff_ffff);
        // front push from position zero wraps to the top of the ring
        send_cmd(MODE_PUSH_FRONT, 32'sh8000_0000);
        send_cmd(MODE_PUSH_BACK, 32'sd0);
        send_cmd(MODE_PUSH_FRONT, -32'sd1);
        send_cmd(MODE_PUSH_BACK, 32'sd1);
        send_cmd(MODE_READ_FWD, 32'sd0);
        send_cmd(MODE_READ_REV, 32'sd0);
        send_cmd(MODE_SPARE_LO, 32'sh5555_5555);
        send_cmd(MODE_SPARE_HI, 32'shaaaa_aaaa);
        send_cmd(MODE_POP_FRONT, 32'sd0);
        send_cmd(MODE_POP_BACK, 32'sd0);
        send_cmd(MODE_READ_FWD, 32'sd0);
        send_cmd(MODE_POP_FRONT, 32'sd0);
        send_cmd(MODE_POP_BACK, 32'sd0);
        send_cmd(MODE_POP_FRONT, 32'sd0);
        send_cmd(MODE_POP_BACK, 32'sd0);
        send_cmd(MODE_READ_REV, 32'sd0);
        wait_drained();
    endtask

    task automatic test_full_queue();
        logic [MODE_W-1:0] mode;
        no_idle = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
            mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            send_cmd(mode, rand_value());
        end
        send_cmd(MODE_PUSH_FRONT, rand_value());
        send_cmd(MODE_PUSH_BACK, rand_value());
        no_idle = 1'b0;
        send_cmd(MODE_READ_FWD, rand_value());
        send_cmd(MODE_READ_REV, rand_value());
        for (int i = 0; i < DEPTH; i++) begin
            mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
            send_cmd(mode, rand_value());
        end
        send_cmd(MODE_POP_BACK, rand_value());
        wait_drained();
    endtask

    // a result waits behind a long stall and the input backs up
    task automatic test_output_stall();
        hold_req = 1'b1;
        no_idle = 1'b1;
        for (int i = 0; i < 20; i++)
            send_cmd(MODE_PUSH_BACK, rand_value());
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_mix();
        int push_pct [6] = '{70, 30, 55, 90, 15, 50};
        int unsigned sent;
        int unsigned r;
        for (int seg = 0; seg < 6; seg++) begin
            sent = 0;
            no_idle = (seg == 3);
            while (sent < 48) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    send_cmd($urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO,
                             rand_value());
                end else begin
                    if (r < 3 + push_pct[seg])
                        send_cmd($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
                                 rand_value());
                    else if (r < 93)
                        send_cmd($urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK,
                                 rand_value());
                    else
                        send_cmd($urandom_range(0, 1) ? MODE_READ_FWD : MODE_READ_REV,
                                 rand_value());
                    sent++;
                end
            end
            if (seg == 2)
                wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.mode = MODE_PUSH_FRONT;
        cmd_ch.value = '0;
        res_ch.ready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        rcv_wait = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        front_pos = 0;
        fill_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_queue();
        test_output_stall();
        test_random_mix();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/deq_pkg.sv
src/deq_if.sv
src/deq_ram.sv
src/deq_out.sv
src/deq_ctrl.sv
src/double_ended_queue.sv
tb/double_ended_queue_test.sv
